// ----- design/range_add_max_segment_tree_core_macros.svh -----
// Assertion macros for the checker file of the interval booking core.
`ifndef RANGE_ADD_MAX_SEGMENT_TREE_CORE_MACROS_SVH
`define RANGE_ADD_MAX_SEGMENT_TREE_CORE_MACROS_SVH

// Checked on every rising edge outside reset.
`define RAMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define RAMST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/ramst_pkg.sv -----
// Shared constants, types and control codes of the interval booking core.
`timescale 1ns / 1ps

package ramst_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned START_W = 10;
  localparam int unsigned END_W   = 11;
  localparam int unsigned OUT_W   = 16;

  localparam int unsigned SLOT_COUNT = 1 << COORD_BITS;
  localparam int unsigned ADDR_W     = COORD_BITS;
  localparam int unsigned NODE_W     = COORD_BITS + 1;
  localparam int unsigned LR_W       = COORD_BITS + 2;
  localparam int unsigned EXT_W      = (END_W > LR_W) ? END_W : LR_W;
  localparam int unsigned LVL_W      = $clog2(COORD_BITS + 1);
  localparam int unsigned WORD_W     = 4 * COUNT_BITS;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [LR_W-1:0]       lr_t;
  typedef logic [LVL_W-1:0]      lvl_t;

  // One child of a parent word: its maximum and its pending add.
  typedef struct packed {
    cnt_t t;
    cnt_t d;
  } half_t;

  typedef half_t [1:0] word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_CALC,
    ST_WRB,
    ST_ROOT,
    ST_DONE
  } step_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_CLR_BUSY,
    C_NO_IN,
    C_EMPTY,
    C_NOT_LAST,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic in_ready;
    logic clr_wr;
    logic rd_first;
    logic rd_next;
    logic calc;
    logic wr_b;
    logic root_upd;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic empty;
    logic last_level;
    logic clr_done;
    logic out_free;
  } stat_t;

endpackage

// ----- design/ramst_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module ramst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// ----- design/ramst_seq.sv -----
// Microcode sequencer: step register, control store and jump logic.
`timescale 1ns / 1ps

module ramst_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ramst_pkg::stat_t  stat_i,
  output ramst_pkg::ctrl_t  ctrl_o
);
  import ramst_pkg::*;

  typedef struct packed {
    ctrl_t ctrl;
    cond_e cond;
    step_e jump;
    step_e next;
  } uword_t;

  function automatic uword_t ucode(step_e s);
    uword_t u;
    u.ctrl = '0;
    u.cond = C_NEVER;
    u.jump = ST_IDLE;
    u.next = ST_IDLE;
    case (s)
      ST_CLEAR: begin
        u.ctrl.clr_wr = 1'b1;
        u.cond = C_CLR_BUSY;
        u.jump = ST_CLEAR;
        u.next = ST_IDLE;
      end
      ST_IDLE: begin
        u.ctrl.in_ready = 1'b1;
        u.cond = C_NO_IN;
        u.jump = ST_IDLE;
        u.next = ST_ISSUE;
      end
      ST_ISSUE: begin
        u.ctrl.rd_first = 1'b1;
        u.cond = C_EMPTY;
        u.jump = ST_DONE;
        u.next = ST_CALC;
      end
      ST_CALC: begin
        u.ctrl.rd_next = 1'b1;
        u.ctrl.calc = 1'b1;
        u.next = ST_WRB;
      end
      ST_WRB: begin
        u.ctrl.wr_b = 1'b1;
        u.cond = C_NOT_LAST;
        u.jump = ST_CALC;
        u.next = ST_ROOT;
      end
      ST_ROOT: begin
        u.ctrl.root_upd = 1'b1;
        u.next = ST_DONE;
      end
      ST_DONE: begin
        u.ctrl.out_load = 1'b1;
        u.cond = C_OUT_BUSY;
        u.jump = ST_DONE;
        u.next = ST_IDLE;
      end
      default: begin
        u.next = ST_IDLE;
      end
    endcase
    return u;
  endfunction

  step_e  upc_q;
  step_e  upc_d;
  uword_t uw;
  logic   taken;

  assign uw = ucode(upc_q);

  always_comb begin
    case (uw.cond)
      C_NEVER:    taken = 1'b0;
      C_CLR_BUSY: taken = !stat_i.clr_done;
      C_NO_IN:    taken = !stat_i.in_valid;
      C_EMPTY:    taken = stat_i.empty;
      C_NOT_LAST: taken = !stat_i.last_level;
      C_OUT_BUSY: taken = !stat_i.out_free;
      default:    taken = 1'b0;
    endcase
    upc_d = taken ? uw.jump : uw.next;
  end

  always_comb begin
    ctrl_o = uw.ctrl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- design/ramst_dp.sv -----
// Datapath: tree memory, boundary paths, level update, root and output register.
`timescale 1ns / 1ps

module ramst_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ramst_pkg::ctrl_t                ctrl_i,
  output ramst_pkg::stat_t                stat_o,
  input  logic                            in_valid_i,
  input  logic [ramst_pkg::START_W-1:0]   start_slot_i,
  input  logic [ramst_pkg::END_W-1:0]     end_slot_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [ramst_pkg::OUT_W-1:0]     max_overlap_o
);
  import ramst_pkg::*;

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  // Children on a boundary path above the leaves take their maximum from the
  // parent word processed one level lower; all others only see a direct add.
  function automatic half_t upd_half(half_t h, logic inc, logic on_a, logic on_b,
                                     cnt_t ma, cnt_t mb, logic leaf);
    half_t r;
    cnt_t  d_n;
    d_n = sat_add(h.d, cnt_t'(inc));
    r.d = d_n;
    if (!leaf && on_a) begin
      r.t = sat_add(ma, d_n);
    end else if (!leaf && on_b) begin
      r.t = sat_add(mb, d_n);
    end else begin
      r.t = sat_add(h.t, cnt_t'(inc));
    end
    return r;
  endfunction

  logic [EXT_W-1:0] start_ext;
  logic [EXT_W-1:0] end_ext;
  logic [EXT_W-1:0] end_clip;
  logic             in_empty;
  logic             accept;
  node_t            lo_node;
  node_t            hi_node;
  lr_t              r_init;

  lr_t   l_q;
  lr_t   r_q;
  node_t a_q;
  node_t b_q;
  cnt_t  ma_q;
  cnt_t  mb_q;
  addr_t wb_addr_q;
  word_t wb_data_q;
  lvl_t  lvl_q;
  logic  empty_q;
  addr_t clr_q;
  cnt_t  root_t_q;
  cnt_t  root_d_q;
  cnt_t  root_t_d;
  cnt_t  root_d_d;
  logic  out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic  apply_l;
  logic  apply_r;
  lr_t   l_inc;
  lr_t   r_dec;
  logic  leaf;
  logic  root_inc;
  addr_t par [2];
  word_t rd_w [2];
  word_t new_w [2];
  cnt_t  new_m [2];

  logic              ram_we;
  addr_t             ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  addr_t             ram_raddr_a;
  addr_t             ram_raddr_b;
  logic [WORD_W-1:0] ram_rd_a;
  logic [WORD_W-1:0] ram_rd_b;
  logic              out_free;

  always_comb begin
    start_ext = EXT_W'(start_slot_i);
    end_ext   = EXT_W'(end_slot_i);
    end_clip  = (end_ext > EXT_W'(SLOT_COUNT)) ? EXT_W'(SLOT_COUNT) : end_ext;
    in_empty  = end_clip <= start_ext;
    lo_node   = NODE_W'(start_ext + EXT_W'(SLOT_COUNT));
    hi_node   = NODE_W'(end_clip + EXT_W'(SLOT_COUNT) - EXT_W'(1));
    r_init    = LR_W'(end_clip + EXT_W'(SLOT_COUNT));
  end

  assign accept = ctrl_i.in_ready && in_valid_i;

  always_comb begin
    apply_l  = l_q[0] && (l_q < r_q);
    l_inc    = l_q + LR_W'(apply_l);
    apply_r  = r_q[0] && (l_inc < r_q);
    r_dec    = r_q - LR_W'(apply_r);
    leaf     = lvl_q == LVL_W'(1);
    root_inc = l_q[0] && (l_q < r_q);
    root_d_d = sat_add(root_d_q, cnt_t'(root_inc));
    root_t_d = sat_add(ma_q, root_d_d);
  end

  always_comb begin
    lr_t  child;
    logic inc;
    par[0]  = ADDR_W'(a_q >> 1);
    par[1]  = ADDR_W'(b_q >> 1);
    rd_w[0] = word_t'(ram_rd_a);
    rd_w[1] = word_t'(ram_rd_b);
    for (int p = 0; p < 2; p++) begin
      for (int h = 0; h < 2; h++) begin
        child = {1'b0, par[p], 1'(h)};
        inc   = (apply_l && (child == l_q)) || (apply_r && (child == r_dec));
        new_w[p][h] = upd_half(rd_w[p][h], inc, child == {1'b0, a_q},
                               child == {1'b0, b_q}, ma_q, mb_q, leaf);
      end
      new_m[p] = (new_w[p][1].t > new_w[p][0].t) ? new_w[p][1].t : new_w[p][0].t;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    if (ctrl_i.clr_wr) begin
      ram_we = 1'b1;
    end else if (ctrl_i.calc) begin
      ram_we    = 1'b1;
      ram_waddr = par[0];
      ram_wdata = new_w[0];
    end else if (ctrl_i.wr_b) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr_q;
      ram_wdata = wb_data_q;
    end
    ram_re      = ctrl_i.rd_first || ctrl_i.rd_next;
    ram_raddr_a = ctrl_i.rd_first ? ADDR_W'(a_q >> 1) : ADDR_W'(a_q >> 2);
    ram_raddr_b = ctrl_i.rd_first ? ADDR_W'(b_q >> 1) : ADDR_W'(b_q >> 2);
  end

  ramst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_tree_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rd_a),
    .rdata_b_o (ram_rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      l_q     <= LR_W'(lo_node);
      r_q     <= r_init;
      a_q     <= lo_node;
      b_q     <= hi_node;
      lvl_q   <= LVL_W'(1);
      empty_q <= in_empty;
    end else begin
      if (ctrl_i.calc) begin
        l_q       <= l_inc >> 1;
        r_q       <= r_dec >> 1;
        a_q       <= a_q >> 1;
        b_q       <= b_q >> 1;
        ma_q      <= new_m[0];
        mb_q      <= new_m[1];
        wb_addr_q <= par[1];
        wb_data_q <= new_w[1];
      end
      if (ctrl_i.wr_b) begin
        lvl_q <= lvl_q + LVL_W'(1);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      root_t_q    <= '0;
      root_d_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_wr) begin
        clr_q <= clr_q + addr_t'(1);
      end
      if (ctrl_i.root_upd) begin
        root_t_q <= root_t_d;
        root_d_q <= root_d_d;
      end
      if (ctrl_i.out_load && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load && out_free) begin
      out_data_q <= OUT_W'(root_t_q);
    end
  end

  always_comb begin
    stat_o.in_valid   = in_valid_i;
    stat_o.empty      = empty_q;
    stat_o.last_level = lvl_q == LVL_W'(COORD_BITS);
    stat_o.clr_done   = clr_q == '1;
    stat_o.out_free   = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign max_overlap_o = out_data_q;

endmodule

// ----- design/range_add_max_segment_tree_core.sv -----
// Top level of the interval booking core: range add and global maximum over a tree.
//
//   channel  handshake                  payload
//   -------  -------------------------  ------------------------------
//   in       in_valid_i / in_ready_o    start_slot_i, end_slot_i
//   out      out_valid_o / out_ready_i  max_overlap_o
//
// A booking passes an issue step, a calculate and a write-back step per tree
// level along both edges, a root update and an output step.
// An empty or reversed interval skips the tree walk and returns the current maximum.
// After reset a clearing pass zeroes every word of the tree memory.
// A result held by the output register stalls the sequencer at its last step.
`timescale 1ns / 1ps

module range_add_max_segment_tree_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ramst_pkg::START_W-1:0]  start_slot_i,
  input  logic [ramst_pkg::END_W-1:0]    end_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ramst_pkg::OUT_W-1:0]    max_overlap_o
);
  import ramst_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ramst_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  ramst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .in_valid_i    (in_valid_i),
    .start_slot_i  (start_slot_i),
    .end_slot_i    (end_slot_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .max_overlap_o (max_overlap_o)
  );

  assign in_ready_o = ctrl.in_ready;

endmodule

// ----- design/ramst_checker.sv -----
// Port-level checker for the interval booking core and its bind.
`timescale 1ns / 1ps
`include "range_add_max_segment_tree_core_macros.svh"

module ramst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ramst_pkg::OUT_W-1:0]   max_overlap_o
);

  `RAMST_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(max_overlap_o), "stalled result beat changed")
  `RAMST_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while busy")
  `RAMST_ASSERT(a_out_after_work, $rose(out_valid_o) |-> $past(!in_ready_o), "result beat without work")
  `RAMST_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o && !in_ready_o, "handshake active in reset")

endmodule

bind range_add_max_segment_tree_core ramst_checker u_ramst_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the interval booking core with a segment tree predictor.
`timescale 1ns / 1ps

module tb;
  import ramst_pkg::*;

  localparam int unsigned TREE_SIZE = 2 * SLOT_COUNT;
  localparam int unsigned LATENCY = 2 * COORD_BITS + 4;
  localparam int unsigned RANDOM_BOOKINGS = 1750;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  class booking_scoreboard;
    cnt_t peak_of[TREE_SIZE];
    cnt_t lazy_of[TREE_SIZE];
    logic [OUT_W-1:0] expected_peaks[$];
    int unsigned mismatches;
    int unsigned bookings;
    int unsigned ignored;
    int unsigned checked;

    function new();
      foreach (peak_of[i]) begin
        peak_of[i] = '0;
        lazy_of[i] = '0;
      end
      mismatches = 0;
      bookings = 0;
      ignored = 0;
      checked = 0;
    endfunction

    function cnt_t sat_add(cnt_t a, cnt_t b);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    endfunction

    function void push_down(int unsigned node);
      cnt_t carry;
      int unsigned kid;
      carry = lazy_of[node];
      kid = 2 * node;
      if (carry != '0 && kid + 1 < TREE_SIZE) begin
        peak_of[kid] = sat_add(peak_of[kid], carry);
        lazy_of[kid] = sat_add(lazy_of[kid], carry);
        peak_of[kid+1] = sat_add(peak_of[kid+1], carry);
        lazy_of[kid+1] = sat_add(lazy_of[kid+1], carry);
      end
      lazy_of[node] = '0;
    endfunction

    function void add_slots(int unsigned node, int unsigned lo, int unsigned hi,
                            int unsigned qlo, int unsigned qhi);
      int unsigned mid;
      if (node >= TREE_SIZE) return;
      if (lo == hi) begin
        peak_of[node] = sat_add(peak_of[node], cnt_t'(1));
        return;
      end
      if (lo >= qlo && hi <= qhi) begin
        peak_of[node] = sat_add(peak_of[node], cnt_t'(1));
        lazy_of[node] = sat_add(lazy_of[node], cnt_t'(1));
        return;
      end
      push_down(node);
      mid = lo + (hi - lo) / 2;
      if (qlo <= mid) add_slots(2 * node, lo, mid, qlo, qhi);
      if (qhi > mid) add_slots(2 * node + 1, mid + 1, hi, qlo, qhi);
      peak_of[node] = (peak_of[2*node] > peak_of[2*node+1]) ?
                      peak_of[2*node] : peak_of[2*node+1];
    endfunction

    function void note_booking(logic [START_W-1:0] first, logic [END_W-1:0] past);
      int unsigned lo;
      int unsigned stop;
      lo = first;
      stop = (past > SLOT_COUNT) ? SLOT_COUNT : past;
      if (stop > lo) begin
        add_slots(1, 0, SLOT_COUNT - 1, lo, stop - 1);
        bookings++;
      end else begin
        ignored++;
      end
      expected_peaks.push_back(OUT_W'(peak_of[1]));
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_peak(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_peaks.size() == 0) begin
        report($sformatf("result max_overlap=%0d arrived with none expected", got));
        return;
      end
      want = expected_peaks.pop_front();
      checked++;
      if (got !== want) begin
        report($sformatf("result %0d: max_overlap=%0d, expected %0d", checked, got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [START_W-1:0] start_slot_i;
  logic [END_W-1:0] end_slot_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [OUT_W-1:0] max_overlap_o;

  booking_scoreboard sb;
  logic [START_W-1:0] start_q[$];
  logic [END_W-1:0] end_q[$];
  longint unsigned cycles = 0;

  range_add_max_segment_tree_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_slot_i (start_slot_i),
    .end_slot_i   (end_slot_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .max_overlap_o(max_overlap_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, sb.expected_peaks.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_booking(int unsigned first, int unsigned past);
    start_q.push_back(START_W'(first));
    end_q.push_back(END_W'(past));
  endtask

  task automatic queue_random_booking();
    int unsigned pick;
    int unsigned first;
    int unsigned span;
    int unsigned k;
    pick = $urandom_range(0, 99);
    first = $urandom_range(0, SLOT_COUNT - 1);
    if (pick < 35) begin
      queue_booking(first, first + $urandom_range(1, 16));
    end else if (pick < 65) begin
      queue_booking(first, $urandom_range(first + 1, SLOT_COUNT));
    end else if (pick < 75) begin
      queue_booking($urandom_range(0, 63), $urandom_range(SLOT_COUNT - 64, SLOT_COUNT));
    end else if (pick < 83) begin
      k = $urandom_range(0, COORD_BITS);
      span = 1 << k;
      queue_booking($urandom_range(0, (SLOT_COUNT >> k) - 1) * span,
                    $urandom_range(0, (SLOT_COUNT >> k) - 1) * span + span);
      start_q[$] = START_W'(int'(end_q[$]) - span);
    end else if (pick < 91) begin
      queue_booking(first, $urandom_range(SLOT_COUNT + 1, (1 << END_W) - 1));
    end else begin
      queue_booking(first, $urandom_range(0, first));
    end
  endtask

  task automatic drive_bookings();
    int unsigned gap;
    bit calm;
    calm = 1'b0;
    for (int i = 0; i < start_q.size(); i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      start_slot_i <= start_q[i];
      end_slot_i <= end_q[i];
      do @(posedge clk_i); while (!in_ready_o);
      sb.note_booking(start_q[i], end_q[i]);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic collect_results();
    int unsigned stall;
    int unsigned count;
    bit calm;
    calm = 1'b0;
    count = 0;
    forever begin
      if (count % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_peak(max_overlap_o);
      count++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    start_slot_i = '0;
    end_slot_i = '0;
    out_ready_i = 1'b0;
    sb = new();

    // The first four requests are empty or reversed so that they see an untouched tree.
    queue_booking(0, 0);
    queue_booking(5, 5);
    queue_booking(10, 3);
    queue_booking(SLOT_COUNT - 1, 0);
    queue_booking(0, 1);
    queue_booking(SLOT_COUNT - 1, SLOT_COUNT);
    queue_booking(0, SLOT_COUNT);
    queue_booking(0, (1 << END_W) - 1);
    queue_booking(SLOT_COUNT - 1, (1 << END_W) - 1);
    queue_booking(SLOT_COUNT / 2, SLOT_COUNT / 2 + 1);
    queue_booking(SLOT_COUNT / 2 - 1, SLOT_COUNT / 2 + 1);
    queue_booking(0, SLOT_COUNT / 2);
    queue_booking(SLOT_COUNT / 2, SLOT_COUNT);
    queue_booking(1, SLOT_COUNT - 1);
    queue_booking(341, 682);
    queue_booking('h2AA, 'h555);
    queue_booking('h155, 'h6AA);
    queue_booking(SLOT_COUNT - 1, SLOT_COUNT - 1);
    queue_booking(SLOT_COUNT - 1, SLOT_COUNT + 1);
    queue_booking(3, 4);
    queue_booking(3, 4);
    queue_booking(0, SLOT_COUNT);
    repeat (RANDOM_BOOKINGS) queue_random_booking();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      collect_results();
    join_none
    drive_bookings();
    while (sb.expected_peaks.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Booked %0d intervals and sent %0d empty or reversed requests.",
             sb.bookings, sb.ignored);
    $display("Checked %0d results; the final peak overlap was %0d.",
             sb.checked, sb.peak_of[1]);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ramst_pkg.sv
design/ramst_ram.sv
design/ramst_seq.sv
design/ramst_dp.sv
design/range_add_max_segment_tree_core.sv
design/ramst_checker.sv
dv/tb.sv
